@@ rtl/srpg_pkg.sv @@
package srpg_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_VAC  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  localparam logic CFG_START_INTERVAL = 1'b0;
  localparam logic CFG_DECEL_STEPS    = 1'b1;

  localparam int CFG_W      = 16;
  localparam int POS_W      = 20;
  localparam int STEPS_W    = 21;
  localparam int SPEED_W    = 16;
  localparam int FIELD_AXES = 3;

  localparam logic [CFG_W-1:0] START_INTERVAL_RST = 16'd150;
  localparam logic [CFG_W-1:0] DECEL_STEPS_RST    = 16'd100;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;

endpackage

@@ rtl/stepper_ramp_pulse_generator_unit.sv @@
// Pipeline: each input transaction is registered into stage 1, and its result is then
// registered in the output register, where the master side can take it. Throughput: one
// transaction per cycle while the master side does not hold back a result; the axis state
// row is kept in a one-entry synchronous memory, and a write-back of the previous item is
// forwarded to the next read. Reset: asynchronous, active low; clears all axis state, the
// vacuum level and the pipeline, and loads the configuration registers with their default values.
module stepper_ramp_pulse_generator_unit #(
  parameter int NUM_AXES      = 3,
  parameter int INTERVAL_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // target_x, target_y, target_z, speed, vacuum_on, zero fill
  input  logic [srpg_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // command
  input  logic [1:0]                         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // step_x, step_y, step_z, dir_x, dir_y, dir_z, vacuum, busy_res
  output logic [srpg_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [srpg_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int IB  = INTERVAL_BITS;
  localparam int PW  = srpg_pkg::POS_W;
  localparam int SW  = srpg_pkg::STEPS_W;
  localparam int FA  = srpg_pkg::FIELD_AXES;

  typedef struct packed {
    logic                 pin;
    logic                 dir;
    logic [SW-1:0]        steps;
    logic [IB-1:0]        tick;
    logic [IB-1:0]        ivl;
    logic [IB-1:0]        goal;
    logic signed [PW-1:0] pos;
  } axis_t;

  typedef struct packed {
    axis_t [NUM_AXES-1:0] ax;
    logic                 vac;
  } row_t;

  logic [srpg_pkg::CFG_W-1:0] start_q, decel_q;

  logic               s1_valid_q;
  srpg_pkg::cmd_e     s1_cmd_q;
  logic [srpg_pkg::IN_DATA_W-1:0] s1_data_q;
  logic               use_fwd_q;
  row_t               fwd_q, rd_q, cur, nxt;
  row_t               mem_q [1];
  logic               mem_valid_q;

  logic               out_valid_q;
  logic [srpg_pkg::OUT_DATA_W-1:0] out_q, out_d;

  logic               s1_fire, in_fire;
  axis_t [NUM_AXES-1:0] tick_ax, move_ax;
  logic signed [PW-1:0] tgt [FA];
  logic [IB-1:0]      goal_v, start_v;
  logic [NUM_AXES-1:0] busy_v;

  assign s1_fire         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= srpg_pkg::START_INTERVAL_RST;
      decel_q <= srpg_pkg::DECEL_STEPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srpg_pkg::CFG_START_INTERVAL: start_q <= cfg_wdata_i;
        srpg_pkg::CFG_DECEL_STEPS:    decel_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      use_fwd_q   <= 1'b0;
      mem_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        use_fwd_q  <= s1_fire;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        mem_valid_q <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_q[0] <= nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= srpg_pkg::cmd_e'(s_axis_tuser_i);
      s1_data_q <= s_axis_tdata_i;
      fwd_q     <= nxt;
      rd_q      <= mem_valid_q ? mem_q[0] : '0;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign cur = use_fwd_q ? fwd_q : rd_q;

  assign tgt[0] = s1_data_q[PW-1:0];
  assign tgt[1] = s1_data_q[2*PW-1:PW];
  assign tgt[2] = s1_data_q[3*PW-1:2*PW];

  always_comb begin
    goal_v  = IB'(s1_data_q[3*PW+srpg_pkg::SPEED_W-1:3*PW]);
    start_v = IB'(start_q);
    if (goal_v == '0) begin
      goal_v = IB'(1);
    end
    if (start_v == '0) begin
      start_v = IB'(1);
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    always_comb begin
      logic [IB-1:0] t;
      logic [SW-1:0] sl;
      t  = cur.ax[a].tick + 1'b1;
      sl = cur.ax[a].steps - 1'b1;
      tick_ax[a] = cur.ax[a];
      if (cur.ax[a].steps != '0) begin
        if (t == cur.ax[a].ivl) begin
          tick_ax[a].tick = '0;
          if (cur.ax[a].pin) begin
            tick_ax[a].pin   = 1'b0;
            tick_ax[a].steps = sl;
            if (cur.ax[a].ivl > cur.ax[a].goal && sl > SW'(decel_q)) begin
              tick_ax[a].ivl = cur.ax[a].ivl - 1'b1;
            end else if (cur.ax[a].ivl != '1) begin
              tick_ax[a].ivl = cur.ax[a].ivl + 1'b1;
            end
          end else begin
            tick_ax[a].pin = 1'b1;
          end
        end else begin
          tick_ax[a].tick = t;
        end
      end
    end

    if (a < FA) begin : g_move
      always_comb begin
        logic signed [SW-1:0] delta;
        delta = {tgt[a][PW-1], tgt[a]} - {cur.ax[a].pos[PW-1], cur.ax[a].pos};
        move_ax[a]      = cur.ax[a];
        move_ax[a].pos  = tgt[a];
        move_ax[a].ivl  = start_v;
        move_ax[a].goal = goal_v;
        if (delta[SW-1]) begin
          move_ax[a].dir   = 1'b0;
          move_ax[a].steps = -delta;
        end else begin
          move_ax[a].dir   = 1'b1;
          move_ax[a].steps = delta;
        end
      end
    end else begin : g_idle
      always_comb begin
        move_ax[a]      = cur.ax[a];
        move_ax[a].ivl  = start_v;
        move_ax[a].goal = goal_v;
      end
    end

    assign busy_v[a] = (nxt.ax[a].steps != '0);
  end

  always_comb begin
    nxt = cur;
    unique case (s1_cmd_q)
      srpg_pkg::CMD_TICK: nxt.ax = tick_ax;
      srpg_pkg::CMD_MOVE: nxt.ax = move_ax;
      srpg_pkg::CMD_VAC:  nxt.vac = s1_data_q[3*PW+srpg_pkg::SPEED_W];
      srpg_pkg::CMD_NONE: nxt = cur;
    endcase
  end

  always_comb begin
    out_d = '0;
    for (int a = 0; a < FA; a++) begin
      if (a < NUM_AXES) begin
        out_d[a]      = nxt.ax[a].pin;
        out_d[FA + a] = nxt.ax[a].dir;
      end
    end
    out_d[2*FA]     = nxt.vac;
    out_d[2*FA + 1] = |busy_v;
  end

endmodule

@@ rtl/srpg_checker.sv @@
module srpg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid right after reset");

  // The input side only stalls when a result is held back downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output backpressure");

  // A waiting result is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result changed while stalled");

  // A result valid that rises was started by an earlier input transaction.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a transaction");

endmodule

bind stepper_ramp_pulse_generator_unit srpg_checker u_srpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
